FILE: rtl/core/tdl_pkg.sv
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared codes, character constants and types of the template delimiter lexer.
// ----------------------------------------------------------------------------
package tdl_pkg;

  localparam int MAX_RES = 3;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // lexer mode codes
  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_OPEN  = 2'd1;
  localparam logic [1:0] MODE_CODE  = 2'd2;
  localparam logic [1:0] MODE_QMARK = 2'd3;

  // quote kind codes
  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] quote;
    logic       esc;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_code;
    logic       segment_end;
  } lex_res_t;

  typedef lex_res_t [MAX_RES-1:0] lex_bundle_t;

endpackage

FILE: rtl/core/tdl_if.sv
// ----------------------------------------------------------------------------
// tdl_if
// Valid/ready channels for source bytes and lexer results.
// ----------------------------------------------------------------------------
interface tdl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface tdl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       in_code;
  logic       segment_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_valid, output in_code,
                  output segment_end, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input in_code,
                input segment_end, input last_of_run, output ready);
endinterface

FILE: rtl/core/template_delimiter_lexer_unit.sv
// ----------------------------------------------------------------------------
// template_delimiter_lexer_unit
// Splits a template byte stream into text and code segments at '{?' / '?}'.
// ----------------------------------------------------------------------------
// in_chan carries one source byte per transfer with end_of_text on the last
// byte of a source. out_chan carries results: passed-on bytes tagged text or
// code, and pure segment-end marks; last_of_run flags the final result of a
// source byte. A byte may yield no result at all (a held '{', '?' or an
// escape backslash).
// The first result of a byte is offered the cycle after its transfer. A
// byte's results leave the result register one per transfer; the next
// byte is taken in the cycle its last result leaves, so bytes with at most
// one result stream at one per cycle while out_chan does not stall. The
// result register is the only limit on rate.
// A stall on out_chan holds the current result and backs up in_chan once
// the result register cannot be freed.
// Reset returns the lexer to plain text, no quote open, no escape pending,
// and drops any results not yet delivered. After end_of_text the lexer
// also returns to that state, so the next byte starts a new source.
// ----------------------------------------------------------------------------
module template_delimiter_lexer_unit (
  input  logic      clk,
  input  logic      rst_n,
  tdl_in_if.sink    in_chan,
  tdl_out_if.source out_chan
);
  import tdl_pkg::*;

  logic             accept;
  logic             can_load;
  lex_bundle_t      res;
  logic [CNT_W-1:0] res_cnt;

  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid && can_load;

  tdl_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_in     (in_chan.char_in),
    .end_of_text (in_chan.end_of_text),
    .res         (res),
    .res_cnt     (res_cnt)
  );

  tdl_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .res      (res),
    .res_cnt  (res_cnt),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

FILE: rtl/core/tdl_scan.sv
// ----------------------------------------------------------------------------
// tdl_scan
// Lexer state register and the per-byte decision that yields up to three
// results for one source byte.
// ----------------------------------------------------------------------------
module tdl_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           char_in,
  input  logic                 end_of_text,
  output tdl_pkg::lex_bundle_t res,
  output logic [tdl_pkg::CNT_W-1:0] res_cnt
);
  import tdl_pkg::*;

  lex_state_t st_r;
  lex_state_t st_nxt;

  always_comb begin
    logic       do_text;
    logic       do_code;
    logic [7:0] q;
    lex_state_t s;
    logic [CNT_W-1:0] n;
    lex_bundle_t r;

    s       = st_r;
    n       = '0;
    r       = '0;
    q       = 8'h00;
    do_text = 1'b0;
    do_code = 1'b0;

    // resolve a pending delimiter first
    case (s.mode)
      MODE_TEXT: begin
        do_text = 1'b1;
      end
      MODE_OPEN: begin
        if (char_in == CH_QMARK) begin
          r[n[IDX_W-1:0]] = '{8'h00, 1'b0, 1'b0, 1'b1};
          n = n + 1'b1;
          s.mode = MODE_CODE;
        end else begin
          r[n[IDX_W-1:0]] = '{CH_OPEN, 1'b1, 1'b0, 1'b0};
          n = n + 1'b1;
          s.mode = MODE_TEXT;
          do_text = 1'b1;
        end
      end
      MODE_CODE: begin
        do_code = 1'b1;
      end
      default: begin
        if (char_in == CH_CLOSE) begin
          r[n[IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1, 1'b1};
          n = n + 1'b1;
          s.mode = MODE_TEXT;
        end else begin
          r[n[IDX_W-1:0]] = '{CH_QMARK, 1'b1, 1'b1, 1'b0};
          n = n + 1'b1;
          s.mode = MODE_CODE;
          do_code = 1'b1;
        end
      end
    endcase

    if (do_text) begin
      if (char_in == CH_OPEN) begin
        s.mode = MODE_OPEN;
      end else begin
        r[n[IDX_W-1:0]] = '{char_in, 1'b1, 1'b0, 1'b0};
        n = n + 1'b1;
      end
    end

    if (do_code) begin
      q = (s.quote == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
      if (s.esc) begin
        r[n[IDX_W-1:0]] = '{CH_BSLASH, 1'b1, 1'b1, 1'b0};
        n = n + 1'b1;
        r[n[IDX_W-1:0]] = '{char_in, 1'b1, 1'b1, 1'b0};
        n = n + 1'b1;
        s.esc = 1'b0;
      end else if (s.quote == QUOTE_SINGLE || s.quote == QUOTE_DOUBLE) begin
        if (char_in == q) begin
          r[n[IDX_W-1:0]] = '{char_in, 1'b1, 1'b1, 1'b0};
          n = n + 1'b1;
          s.quote = QUOTE_NONE;
        end else if (char_in == CH_BSLASH) begin
          s.esc = 1'b1;
        end else begin
          r[n[IDX_W-1:0]] = '{char_in, 1'b1, 1'b1, 1'b0};
          n = n + 1'b1;
        end
      end else begin
        if (char_in == CH_SQUOTE) begin
          r[n[IDX_W-1:0]] = '{char_in, 1'b1, 1'b1, 1'b0};
          n = n + 1'b1;
          s.quote = QUOTE_SINGLE;
        end else if (char_in == CH_DQUOTE) begin
          r[n[IDX_W-1:0]] = '{char_in, 1'b1, 1'b1, 1'b0};
          n = n + 1'b1;
          s.quote = QUOTE_DOUBLE;
        end else if (char_in == CH_QMARK) begin
          s.mode = MODE_QMARK;
        end else begin
          r[n[IDX_W-1:0]] = '{char_in, 1'b1, 1'b1, 1'b0};
          n = n + 1'b1;
        end
      end
    end

    // close out the source: flush a trailing brace, end an open text segment
    if (end_of_text) begin
      if (s.mode == MODE_OPEN) begin
        r[n[IDX_W-1:0]] = '{CH_OPEN, 1'b1, 1'b0, 1'b0};
        n = n + 1'b1;
      end
      if (s.mode == MODE_TEXT || s.mode == MODE_OPEN) begin
        r[n[IDX_W-1:0]] = '{8'h00, 1'b0, 1'b0, 1'b1};
        n = n + 1'b1;
      end
      s = '{MODE_TEXT, QUOTE_NONE, 1'b0};
    end

    st_nxt  = s;
    res     = r;
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{MODE_TEXT, QUOTE_NONE, 1'b0};
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: rtl/core/tdl_emit.sv
// ----------------------------------------------------------------------------
// tdl_emit
// Result register holding one byte's results; presents them one per
// transfer and frees itself on the last one.
// ----------------------------------------------------------------------------
module tdl_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  tdl_pkg::lex_bundle_t res,
  input  logic [tdl_pkg::CNT_W-1:0] res_cnt,
  output logic                 can_load,
  tdl_out_if.source            out_chan
);
  import tdl_pkg::*;

  lex_bundle_t      bundle_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  logic             take;
  logic             last;
  lex_res_t         cur;

  assign cur      = bundle_r[idx_r[IDX_W-1:0]];
  assign last     = (idx_r == cnt_r - 1'b1);
  assign take     = out_chan.valid && out_chan.ready;
  assign can_load = !out_chan.valid || (take && last);

  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.out_byte    = cur.out_byte;
  assign out_chan.byte_valid  = cur.byte_valid;
  assign out_chan.in_code     = cur.in_code;
  assign out_chan.segment_end = cur.segment_end;
  assign out_chan.last_of_run = last;

  always_ff @(posedge clk) begin
    if (load) begin
      bundle_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= res_cnt;
      idx_r <= '0;
    end else if (take && last) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (take) begin
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule
